FILE: sv/bse_pkg.sv
package bse_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned VAL_W = 26;
  localparam int unsigned CFG_W = 5;
  localparam int unsigned IDX_W = 4;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_ITEMS_DEF   = 64;
  localparam int unsigned MAX_BUCKETS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // The value range is 1001.0 in whole units; the bucket setting resets to 8.
  localparam int unsigned RANGE_INT = 1001;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } bse_state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } cell_ctl_t;

  // Control bits that travel with an item through the bucket stages.
  typedef struct packed {
    logic valid;
    logic store;
    logic last;
  } stage_ctl_t;

  // Lower edge of bucket k in the scaled product domain: k * 1001 << frac.
  function automatic logic [63:0] bse_thresh(input int unsigned k,
                                             input int unsigned frac);
    logic [63:0] t;
    t = 64'(k) * 64'(RANGE_INT);
    return t << frac;
  endfunction

endpackage

FILE: sv/bse_cell.sv
module bse_cell #(
  parameter int unsigned TAG_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bse_pkg::cell_ctl_t            ctl,
  input  logic [TAG_W-1:0]              new_tag,
  input  logic [bse_pkg::VAL_W-1:0]     new_val,
  input  logic                          prev_gb,
  input  logic                          prev_valid,
  input  logic [TAG_W-1:0]              prev_tag,
  input  logic [bse_pkg::VAL_W-1:0]     prev_val,
  input  logic                          next_valid,
  input  logic [TAG_W-1:0]              next_tag,
  input  logic [bse_pkg::VAL_W-1:0]     next_val,
  output logic                          gb,
  output logic                          valid,
  output logic [TAG_W-1:0]              tag,
  output logic [bse_pkg::VAL_W-1:0]     val
);

  logic                      valid_r, valid_nxt;
  logic [TAG_W-1:0]          tag_r, tag_nxt;
  logic [bse_pkg::VAL_W-1:0] val_r, val_nxt;

  // The new item belongs at or before this cell when the cell is empty or
  // holds a larger (bucket, value) key.
  assign gb = !valid_r || (new_tag < tag_r) || ((new_tag == tag_r) && (new_val < val_r));

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    val_nxt   = val_r;
    if (ctl.shift_en) begin
      valid_nxt = next_valid;
      tag_nxt   = next_tag;
      val_nxt   = next_val;
    end else if (ctl.ins_en && gb) begin
      if (prev_gb) begin
        valid_nxt = prev_valid;
        tag_nxt   = prev_tag;
        val_nxt   = prev_val;
      end else begin
        valid_nxt = 1'b1;
        tag_nxt   = new_tag;
        val_nxt   = new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    val_r <= val_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign val   = val_r;

endmodule

FILE: sv/bse_bucket.sv
module bse_bucket #(
  parameter int unsigned MAX_BUCKETS = bse_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned FRAC_BITS   = bse_pkg::FRAC_BITS_DEF,
  parameter int unsigned TAG_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bse_pkg::stage_ctl_t           in_ctl,
  input  logic [bse_pkg::VAL_W-1:0]     in_val,
  input  logic [bse_pkg::CFG_W-1:0]     bkt_cfg,
  output bse_pkg::stage_ctl_t           out_ctl,
  output logic [bse_pkg::VAL_W-1:0]     out_val,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int unsigned NB_W = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned PW   = bse_pkg::VAL_W + NB_W;

  logic [NB_W-1:0]           nb_eff;
  bse_pkg::stage_ctl_t       s1_ctl_r, s2_ctl_r;
  logic [bse_pkg::VAL_W-1:0] s1_val_r, s2_val_r;
  logic [PW-1:0]             s1_prod_r;
  logic [NB_W-1:0]           s1_nb_r;
  logic [TAG_W-1:0]          raw_tag, tag_sel, s2_tag_r;
  logic [NB_W-1:0]           nb_top;

  always_comb begin
    if (bkt_cfg == '0) begin
      nb_eff = NB_W'(1);
    end else if (int'(bkt_cfg) > int'(MAX_BUCKETS)) begin
      nb_eff = NB_W'(MAX_BUCKETS);
    end else begin
      nb_eff = NB_W'(bkt_cfg);
    end
  end

  // Highest bucket edge the product reaches; the edges are ascending, so
  // the last match wins.
  always_comb begin
    raw_tag = '0;
    for (int unsigned k = 1; k < MAX_BUCKETS; k++) begin
      if (64'(s1_prod_r) >= bse_pkg::bse_thresh(k, FRAC_BITS)) begin
        raw_tag = TAG_W'(k);
      end
    end
    nb_top  = s1_nb_r - NB_W'(1);
    tag_sel = raw_tag;
    if (int'(raw_tag) > int'(nb_top)) begin
      tag_sel = TAG_W'(nb_top);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      s1_ctl_r <= in_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_val_r  <= in_val;
    s1_prod_r <= PW'(in_val) * PW'(nb_eff);
    s1_nb_r   <= nb_eff;
    s2_val_r  <= s1_val_r;
    s2_tag_r  <= tag_sel;
  end

  assign out_ctl = s2_ctl_r;
  assign out_val = s2_val_r;
  assign out_tag = s2_tag_r;

endmodule

FILE: sv/bucket_sort_engine.sv
// An accepted item passes the multiply stage and then the compare stage of the front
// end before it is inserted into the sorted cell chain; the first result of a batch is
// offered once the batch_end item has left the front end and the state is EMIT.
// Throughput: one item per cycle in LOAD, one result per unstalled cycle in EMIT.
// The input is stalled from the batch_end item until the final result is taken.
// Reset (rst_n, synchronous, active low) empties the chain and sets the bucket count to 8.
module bucket_sort_engine #(
  parameter int unsigned MAX_ITEMS   = bse_pkg::MAX_ITEMS_DEF,
  parameter int unsigned MAX_BUCKETS = bse_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned FRAC_BITS   = bse_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bse_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bse_pkg::VAL_W-1:0]     in_sample_value,
  input  logic                          in_batch_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bse_pkg::VAL_W-1:0]     out_sorted_value,
  output logic [bse_pkg::IDX_W-1:0]     out_bucket_index,
  output logic                          out_final_flag,
  output logic                          out_overflow_flag
);

  localparam int unsigned TAG_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EXT_W = TAG_W + bse_pkg::IDX_W;

  // Config register, to be written by the user only while the block is idle; not enforced.
  logic [bse_pkg::CFG_W-1:0] bkt_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_cfg_r <= bse_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      bkt_cfg_r <= cfg_wr_data;
    end
  end

  // Handshake events.
  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Batch bookkeeping. The counter holds the number of stored items; during
  // emission it counts down the results that are still to be delivered.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             dropped_r, dropped_nxt;
  logic             has_room;
  logic             last_out;

  assign has_room = (cnt_r < CNT_W'(MAX_ITEMS));
  assign last_out = (cnt_r == CNT_W'(1));

  // Front end: the bucket number is found in two registered stages, the
  // multiply by the bucket count and then the compare against the edges.
  bse_pkg::stage_ctl_t       fe_in_ctl, fe_out_ctl;
  logic [bse_pkg::VAL_W-1:0] fe_val;
  logic [TAG_W-1:0]          fe_tag;

  assign fe_in_ctl.valid = in_acc;
  assign fe_in_ctl.store = has_room;
  assign fe_in_ctl.last  = in_batch_end;

  bse_bucket #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .FRAC_BITS   (FRAC_BITS),
    .TAG_W       (TAG_W)
  ) u_bucket (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ctl       (fe_in_ctl),
    .in_val       (in_sample_value),
    .bkt_cfg      (bkt_cfg_r),
    .out_ctl      (fe_out_ctl),
    .out_val      (fe_val),
    .out_tag      (fe_tag)
  );

  // Sequencer. LOAD takes items, DRAIN waits for the batch_end item to
  // leave the front end, EMIT shifts the chain out through cell 0.
  bse_pkg::bse_state_t state_r, state_nxt;
  bse_pkg::cell_ctl_t  cctl;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bse_pkg::ST_LOAD: begin
        if (in_acc && in_batch_end) begin
          state_nxt = bse_pkg::ST_DRAIN;
        end
      end
      bse_pkg::ST_DRAIN: begin
        if (fe_out_ctl.valid && fe_out_ctl.last) begin
          state_nxt = bse_pkg::ST_EMIT;
        end
      end
      bse_pkg::ST_EMIT: begin
        if (out_acc && last_out) begin
          state_nxt = bse_pkg::ST_LOAD;
        end
      end
      default: state_nxt = bse_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cctl.ins_en   = fe_out_ctl.valid && fe_out_ctl.store;
    cctl.shift_en = 1'b0;
    unique case (state_r)
      bse_pkg::ST_LOAD: begin
        in_stall = 1'b0;
      end
      bse_pkg::ST_DRAIN: begin
        in_stall = 1'b1;
      end
      bse_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        cctl.shift_en = out_acc;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    if (in_acc) begin
      if (has_room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (out_acc) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (last_out) begin
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bse_pkg::ST_LOAD;
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // The cell chain stays sorted by (bucket, value) with its valid entries
  // packed from cell 0. An insert finds its slot by a compare in every cell
  // and moves the larger entries one cell to the right; emission shifts the
  // whole chain one cell to the left per result taken.
  logic                      c_gb    [MAX_ITEMS];
  logic                      c_valid [MAX_ITEMS];
  logic [TAG_W-1:0]          c_tag   [MAX_ITEMS];
  logic [bse_pkg::VAL_W-1:0] c_val   [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                      p_gb, p_valid, n_valid;
    logic [TAG_W-1:0]          p_tag, n_tag;
    logic [bse_pkg::VAL_W-1:0] p_val, n_val;

    if (i == 0) begin : g_head
      assign p_gb    = 1'b0;
      assign p_valid = 1'b0;
      assign p_tag   = '0;
      assign p_val   = '0;
    end else begin : g_body
      assign p_gb    = c_gb[i-1];
      assign p_valid = c_valid[i-1];
      assign p_tag   = c_tag[i-1];
      assign p_val   = c_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_tag   = '0;
      assign n_val   = '0;
    end else begin : g_link
      assign n_valid = c_valid[i+1];
      assign n_tag   = c_tag[i+1];
      assign n_val   = c_val[i+1];
    end

    bse_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cctl),
      .new_tag    (fe_tag),
      .new_val    (fe_val),
      .prev_gb    (p_gb),
      .prev_valid (p_valid),
      .prev_tag   (p_tag),
      .prev_val   (p_val),
      .next_valid (n_valid),
      .next_tag   (n_tag),
      .next_val   (n_val),
      .gb         (c_gb[i]),
      .valid      (c_valid[i]),
      .tag        (c_tag[i]),
      .val        (c_val[i])
    );
  end

  // Results come straight from the registers of cell 0.
  logic [EXT_W-1:0] tag_ext;
  assign tag_ext           = EXT_W'(c_tag[0]);
  assign out_sorted_value  = c_val[0];
  assign out_bucket_index  = tag_ext[bse_pkg::IDX_W-1:0];
  assign out_final_flag    = last_out;
  assign out_overflow_flag = dropped_r;

  // A result is only offered from a filled head cell.
  a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> c_valid[0])
    else $error("result offered from an empty head cell");

  // The item count never exceeds the chain length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond capacity");

  // Emission always has at least one item left to deliver.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bse_pkg::ST_EMIT) |-> (cnt_r != '0))
    else $error("emitting with no items left");

  // Inserts and shifts never collide in the chain.
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    cctl.shift_en |-> !cctl.ins_en)
    else $error("insert during emission");

  // After the final result is taken the chain is empty.
  a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && last_out) |=> !c_valid[0])
    else $error("chain not empty after the final result");

endmodule

FILE: bench/bse_checker.sv
`timescale 1ns / 1ps
module bse_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bse_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [bse_pkg::VAL_W-1:0] in_sample_value,
  input  logic                      in_batch_end,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [bse_pkg::VAL_W-1:0] out_sorted_value,
  input  logic [bse_pkg::IDX_W-1:0] out_bucket_index,
  input  logic                      out_final_flag,
  input  logic                      out_overflow_flag,
  output int                        mismatch_count,
  output int                        results_owed
);

  typedef struct packed {
    logic [bse_pkg::VAL_W-1:0] value;
    logic [bse_pkg::IDX_W-1:0] bucket;
    logic                      closes;
    logic                      overflow;
  } sorted_item_t;

  // Key for ordering: bucket in the upper bits, value below.
  typedef logic [bse_pkg::IDX_W+bse_pkg::VAL_W-1:0] order_key_t;

  sorted_item_t              sorted_due[$];
  logic [bse_pkg::VAL_W-1:0] held_value[bse_pkg::MAX_ITEMS_DEF];
  logic [bse_pkg::IDX_W-1:0] held_tag[bse_pkg::MAX_ITEMS_DEF];
  int unsigned               held_count;
  logic                      items_lost;
  logic [bse_pkg::CFG_W-1:0] bucket_setting;

  function automatic logic [bse_pkg::IDX_W-1:0] bucket_of(
      input logic [bse_pkg::VAL_W-1:0] v,
      input logic [bse_pkg::CFG_W-1:0] setting);
    int unsigned nb;
    logic [63:0] b;
    if (setting == '0) begin
      nb = 1;
    end else if (int'(setting) > int'(bse_pkg::MAX_BUCKETS_DEF)) begin
      nb = bse_pkg::MAX_BUCKETS_DEF;
    end else begin
      nb = 32'(setting);
    end
    b = (64'(v) * 64'(nb)) / (64'(bse_pkg::RANGE_INT) << bse_pkg::FRAC_BITS_DEF);
    if (b >= 64'(nb)) begin
      b = 64'(nb - 1);
    end
    return b[bse_pkg::IDX_W-1:0];
  endfunction

  // Orders the held batch by bucket, then by value, and queues one result per entry.
  task automatic release_batch();
    order_key_t   keys[bse_pkg::MAX_ITEMS_DEF];
    order_key_t   k;
    sorted_item_t r;
    int           i;
    int           j;
    for (i = 0; i < int'(held_count); i++) begin
      keys[i] = {held_tag[i], held_value[i]};
    end
    for (i = 1; i < int'(held_count); i++) begin
      k = keys[i];
      j = i;
      while (j > 0 && keys[j-1] > k) begin
        keys[j] = keys[j-1];
        j--;
      end
      keys[j] = k;
    end
    for (i = 0; i < int'(held_count); i++) begin
      r.value    = keys[i][bse_pkg::VAL_W-1:0];
      r.bucket   = keys[i][bse_pkg::IDX_W+bse_pkg::VAL_W-1:bse_pkg::VAL_W];
      r.closes   = (i == int'(held_count) - 1);
      r.overflow = items_lost;
      sorted_due = {sorted_due, r};
    end
    held_count = 0;
    items_lost = 1'b0;
  endtask

  always @(posedge clk) begin
    sorted_item_t want;
    if (!rst_n) begin
      held_count     = 0;
      items_lost     = 1'b0;
      bucket_setting = bse_pkg::CFG_RESET;
      sorted_due.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sorted_due.size() == 0) begin
          $error("result with no item expected: sorted_value %0d", out_sorted_value);
          mismatch_count++;
        end else begin
          want = sorted_due.pop_front();
          if (out_sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, out_sorted_value);
            mismatch_count++;
          end
          if (out_bucket_index !== want.bucket) begin
            $error("bucket_index: expected %0d, got %0d", want.bucket, out_bucket_index);
            mismatch_count++;
          end
          if (out_final_flag !== want.closes) begin
            $error("final_flag: expected %0d, got %0d", want.closes, out_final_flag);
            mismatch_count++;
          end
          if (out_overflow_flag !== want.overflow) begin
            $error("overflow_flag: expected %0d, got %0d", want.overflow,
                   out_overflow_flag);
            mismatch_count++;
          end
        end
      end
      // The item uses the setting in force before a write at the same edge.
      if (in_valid && !in_stall) begin
        if (held_count < bse_pkg::MAX_ITEMS_DEF) begin
          held_value[held_count] = in_sample_value;
          held_tag[held_count]   = bucket_of(in_sample_value, bucket_setting);
          held_count++;
        end else begin
          items_lost = 1'b1;
        end
        if (in_batch_end) begin
          release_batch();
        end
      end
      if (cfg_wr_en) begin
        bucket_setting = cfg_wr_data;
      end
    end
    results_owed = sorted_due.size();
  end

endmodule

FILE: bench/tb_bucket_sort_engine.sv
`timescale 1ns / 1ps
module tb_bucket_sort_engine;

  // Landmark sample values in Q10.16: the top of the legal range, the first value
  // at 1001.0 (which must saturate into the last bucket), and the all-ones pattern.
  localparam logic [bse_pkg::VAL_W-1:0] TOP_VALUE = bse_pkg::VAL_W'(65601535);
  localparam logic [bse_pkg::VAL_W-1:0] RANGE_END = bse_pkg::VAL_W'(65601536);
  localparam logic [bse_pkg::VAL_W-1:0] ALL_ONES  = '1;
  // Width of one bucket when sixteen buckets are in use; edges for a bucket count
  // that divides sixteen are a subset of these.
  localparam int unsigned EDGE_STEP = 4100096;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [bse_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [bse_pkg::VAL_W-1:0] in_sample_value = '0;
  logic                      in_batch_end = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [bse_pkg::VAL_W-1:0] out_sorted_value;
  logic [bse_pkg::IDX_W-1:0] out_bucket_index;
  logic                      out_final_flag;
  logic                      out_overflow_flag;

  int                        mismatch_count;
  int                        results_owed;

  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int unsigned               tx_idle_pct = 8;
  int unsigned               rx_idle_pct = 75;
  // Most recent value sent, reused now and then to produce ties inside a bucket.
  logic [bse_pkg::VAL_W-1:0] recent_value = '0;
  int unsigned               items_sent;
  int unsigned               drain_wait;

  always #4 clk = ~clk;

  bucket_sort_engine u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_value   (in_sample_value),
    .in_batch_end      (in_batch_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_bucket_index  (out_bucket_index),
    .out_final_flag    (out_final_flag),
    .out_overflow_flag (out_overflow_flag)
  );

  // The checker sees exactly what the block sees and keeps its own sorted copy
  // of every batch; the top only reads back the mismatch count and how many
  // results are still owed.
  bse_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_value   (in_sample_value),
    .in_batch_end      (in_batch_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_bucket_index  (out_bucket_index),
    .out_final_flag    (out_final_flag),
    .out_overflow_flag (out_overflow_flag),
    .mismatch_count    (mismatch_count),
    .results_owed      (results_owed)
  );

  // The receiver decides once per falling edge whether to stall the next cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Offers one item, possibly after a random hold-off, and returns at the falling
  // edge after it was accepted. Valid is left high so that the next item can follow
  // back to back; callers that pause must lower it first.
  task automatic push_item(input logic [bse_pkg::VAL_W-1:0] v, input logic closes);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_batch_end    <= closes;
    recent_value = v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    items_sent++;
  endtask

  // Stops sending and waits until every owed result has been taken, then waits on
  // to cover an item still in the two-stage front of the block, since an item
  // without batch_end owes no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // The bucket count is only written while the block is quiet.
  task automatic write_bkt_cfg(input logic [bse_pkg::CFG_W-1:0] setting);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= setting;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly values spread over the legal range, with a share of saturating values,
  // values next to bucket edges, ties and the extremes.
  function automatic logic [bse_pkg::VAL_W-1:0] pick_value();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(99);
    if (sel < 60) begin
      return bse_pkg::VAL_W'($urandom_range(TOP_VALUE, 0));
    end else if (sel < 72) begin
      return bse_pkg::VAL_W'($urandom_range(ALL_ONES, RANGE_END));
    end else if (sel < 85) begin
      k = $urandom_range(15, 1);
      return bse_pkg::VAL_W'(k * EDGE_STEP + $urandom_range(2) - 1);
    end else if (sel < 93) begin
      return recent_value;
    end else begin
      case ($urandom_range(2))
        0: return '0;
        1: return TOP_VALUE;
        default: return ALL_ONES;
      endcase
    end
  endfunction

  task automatic random_batch(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      push_item(pick_value(), (i == n - 1));
    end
  endtask

  // One random phase: small batches of random content, now and then a longer one,
  // with bucket count changes between batches.
  task automatic random_phase(input int unsigned item_goal);
    int unsigned start_count;
    int unsigned pick;
    start_count = items_sent;
    while (items_sent - start_count < item_goal) begin
      if ($urandom_range(99) < 30) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          write_bkt_cfg('0);
        end else if (pick == 1) begin
          write_bkt_cfg('1);
        end else begin
          write_bkt_cfg(bse_pkg::CFG_W'($urandom_range(31)));
        end
      end
      if ($urandom_range(99) < 10) begin
        random_batch($urandom_range(30, 13));
      end else begin
        random_batch($urandom_range(8, 1));
      end
    end
  endtask

  initial begin
    items_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset bucket count of eight: the extremes of the value field, a value at
    // 1001.0 and the all-ones pattern that both saturate, both sides of the first
    // bucket edge and a tie.
    push_item(bse_pkg::VAL_W'(2 * EDGE_STEP), 1'b0);
    push_item('0, 1'b0);
    push_item(ALL_ONES, 1'b0);
    push_item(TOP_VALUE, 1'b0);
    push_item(RANGE_END, 1'b0);
    push_item(bse_pkg::VAL_W'(2 * EDGE_STEP - 1), 1'b0);
    push_item(bse_pkg::VAL_W'(2 * EDGE_STEP), 1'b0);
    push_item(bse_pkg::VAL_W'(1), 1'b1);

    // A bucket count of zero acts as a single bucket.
    write_bkt_cfg('0);
    push_item(bse_pkg::VAL_W'(40000000), 1'b0);
    push_item(bse_pkg::VAL_W'(3), 1'b0);
    push_item(ALL_ONES, 1'b1);

    // The largest setting is clamped to sixteen buckets.
    write_bkt_cfg('1);
    push_item(bse_pkg::VAL_W'(EDGE_STEP - 1), 1'b0);
    push_item(bse_pkg::VAL_W'(EDGE_STEP), 1'b0);
    push_item(TOP_VALUE, 1'b1);

    // Just above the bucket limit, with a batch of a single item.
    write_bkt_cfg(bse_pkg::CFG_W'(bse_pkg::MAX_BUCKETS_DEF + 1));
    push_item(bse_pkg::VAL_W'(15 * EDGE_STEP), 1'b1);

    // Bucket count changed in the middle of a batch: the first two values keep
    // the buckets of the two-bucket setting, the rest fall into the single bucket.
    write_bkt_cfg(bse_pkg::CFG_W'(2));
    push_item(bse_pkg::VAL_W'(8 * EDGE_STEP - 1), 1'b0);
    push_item(bse_pkg::VAL_W'(8 * EDGE_STEP), 1'b0);
    write_bkt_cfg(bse_pkg::CFG_W'(1));
    push_item(bse_pkg::VAL_W'(50000000), 1'b0);
    push_item(bse_pkg::VAL_W'(10), 1'b1);

    // Exactly sixteen buckets with two identical values.
    write_bkt_cfg(bse_pkg::CFG_W'(bse_pkg::MAX_BUCKETS_DEF));
    push_item(bse_pkg::VAL_W'(20000000), 1'b0);
    push_item(bse_pkg::VAL_W'(20000000), 1'b1);

    // Random traffic in three idling regimes: a slow receiver, then a slow sender,
    // then no idling at all.
    tx_idle_pct = 8;
    rx_idle_pct = 75;
    random_phase(12);
    settle();
    tx_idle_pct = 75;
    rx_idle_pct = 8;
    random_phase(12);
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // A batch that overruns the store: items past the capacity, the batch_end item
    // among them, are dropped and every result of the batch flags the overflow.
    random_batch(bse_pkg::MAX_ITEMS_DEF + 2);
    random_phase(12);

    in_valid <= 1'b0;
    @(negedge clk);
    drain_wait = 0;
    while (results_owed != 0 && drain_wait < 20000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends far sooner.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
